FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, command types and address helpers for the text console
// character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = $clog2(CELL_COUNT);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CH_RETURN    = 8'h0D;
  localparam logic [7:0]  CH_BACKSPACE = 8'h08;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  BLANK_ATTR   = 8'h0F;
  localparam logic [15:0] BLANK_CELL   = {BLANK_ATTR, CH_SPACE};

  typedef logic [2:0] op_t;
  localparam op_t OP_READ      = 3'd0;
  localparam op_t OP_NEWLINE   = 3'd1;
  localparam op_t OP_RETURN    = 3'd2;
  localparam op_t OP_BACKSPACE = 3'd3;
  localparam op_t OP_CHAR      = 3'd4;

  typedef struct packed {
    op_t              op;
    logic [7:0]       ch;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             in_range;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic take;
  } back_status_t;

  // Screen rows live in a ring: logical row 0 sits at physical row top.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] s;
    s = {1'b0, r} + {1'b0, top};
    if (s >= (ROW_W + 1)'(SCREEN_ROWS)) begin
      s = s - (ROW_W + 1)'(SCREEN_ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] r);
    return ADDR_W'(r) * ADDR_W'(SCREEN_COLUMNS);
  endfunction

endpackage

FILE: hdl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input items, decodes them into commands and holds them in a short
// queue for the execution side.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               func,
  input  logic [7:0]         char_code,
  input  logic [ROW_W-1:0]   read_row,
  input  logic [COL_W-1:0]   read_col,
  input  back_status_t       back_status,
  output logic               cmd_valid,
  output cmd_t               cmd
);

  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              cmd_in;
  logic              push_ok;
  logic              pop_ok;

  always_comb begin
    cmd_in.ch       = char_code;
    cmd_in.row      = read_row;
    cmd_in.col      = read_col;
    cmd_in.in_range = (32'(read_row) < SCREEN_ROWS) && (32'(read_col) < SCREEN_COLUMNS);
    if (func) begin
      cmd_in.op = OP_READ;
    end else begin
      case (char_code)
        CH_NEWLINE:   cmd_in.op = OP_NEWLINE;
        CH_RETURN:    cmd_in.op = OP_RETURN;
        CH_BACKSPACE: cmd_in.op = OP_BACKSPACE;
        default:      cmd_in.op = OP_CHAR;
      endcase
    end
  end

  // Hold off input while the screen clear runs after reset.
  assign full      = (count == QCNT_W'(QUEUE_DEPTH)) || back_status.clearing;
  assign push_ok   = push && !full;
  assign pop_ok    = back_status.take;
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Executes queued commands against the screen memory and the cursor, runs
// the clear pass after reset and the row blanking on scroll, and holds the
// result register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         text_attribute,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output back_status_t       back_status,
  input  logic               pop,
  output logic               out_valid,
  output logic [15:0]        cell_value,
  output logic [ROW_W-1:0]   cursor_row,
  output logic [COL_W-1:0]   cursor_col,
  output logic               scrolled
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_BLANK = 2'd3;

  logic [15:0]       mem [CELL_COUNT];
  logic [15:0]       rd_data;

  logic [1:0]        state, state_next;
  logic [ADDR_W-1:0] clr_cnt, clr_cnt_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  top, top_next;
  logic [ADDR_W-1:0] blank_base, blank_base_next;
  logic [COL_W-1:0]  blank_col, blank_col_next;
  logic              rd_in_range, rd_in_range_next;
  logic              out_valid_next;
  logic [15:0]       cell_value_next;
  logic [ROW_W-1:0]  cursor_row_next;
  logic [COL_W-1:0]  cursor_col_next;
  logic              scrolled_next;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdata;
  logic              pop_ok, take, go_next_row;
  logic [ADDR_W-1:0] cur_base;

  assign pop_ok   = pop && out_valid;
  assign take     = (state == S_IDLE) && cmd_valid && (!out_valid || pop_ok);
  assign cur_base = row_base(phys_row(cur_row, top));

  assign back_status.clearing = (state == S_CLEAR);
  assign back_status.take     = take;

  always_comb begin
    state_next       = state;
    clr_cnt_next     = clr_cnt;
    cur_row_next     = cur_row;
    cur_col_next     = cur_col;
    top_next         = top;
    blank_base_next  = blank_base;
    blank_col_next   = blank_col;
    rd_in_range_next = rd_in_range;
    out_valid_next   = out_valid && !pop_ok;
    cell_value_next  = cell_value;
    cursor_row_next  = cursor_row;
    cursor_col_next  = cursor_col;
    scrolled_next    = scrolled;
    we               = 1'b0;
    re               = 1'b0;
    waddr            = '0;
    raddr            = '0;
    wdata            = BLANK_CELL;
    go_next_row      = 1'b0;

    case (state)
      S_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_cnt;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_READ: begin
              re               = cmd.in_range;
              raddr            = row_base(phys_row(cmd.row, top)) + ADDR_W'(cmd.col);
              rd_in_range_next = cmd.in_range;
              state_next       = S_READ;
            end
            OP_NEWLINE: begin
              cur_col_next = '0;
              go_next_row  = 1'b1;
            end
            OP_RETURN: begin
              cur_col_next = '0;
            end
            OP_BACKSPACE: begin
              if (cur_col != '0) begin
                cur_col_next = cur_col - 1'b1;
                we           = 1'b1;
                waddr        = cur_base + ADDR_W'(cur_col - 1'b1);
              end
            end
            default: begin
              we    = 1'b1;
              waddr = cur_base + ADDR_W'(cur_col);
              wdata = {text_attribute, cmd.ch};
              if (cur_col == COL_W'(SCREEN_COLUMNS - 1)) begin
                cur_col_next = '0;
                go_next_row  = 1'b1;
              end else begin
                cur_col_next = cur_col + 1'b1;
              end
            end
          endcase

          // Scroll by advancing the ring: the old top row becomes the new
          // bottom row and gets blanked.
          if (go_next_row && (cur_row == ROW_W'(SCREEN_ROWS - 1))) begin
            top_next        = (top == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top + 1'b1;
            blank_base_next = row_base(top);
            blank_col_next  = '0;
            state_next      = S_BLANK;
          end else if (cmd.op != OP_READ) begin
            if (go_next_row) begin
              cur_row_next = cur_row + 1'b1;
            end
            out_valid_next  = 1'b1;
            cell_value_next = '0;
            cursor_row_next = go_next_row ? cur_row + 1'b1 : cur_row;
            cursor_col_next = cur_col_next;
            scrolled_next   = 1'b0;
          end
        end
      end

      S_READ: begin
        out_valid_next  = 1'b1;
        cell_value_next = rd_in_range ? rd_data : '0;
        cursor_row_next = cur_row;
        cursor_col_next = cur_col;
        scrolled_next   = 1'b0;
        state_next      = S_IDLE;
      end

      S_BLANK: begin
        we             = 1'b1;
        waddr          = blank_base + ADDR_W'(blank_col);
        blank_col_next = blank_col + 1'b1;
        if (blank_col == COL_W'(SCREEN_COLUMNS - 1)) begin
          out_valid_next  = 1'b1;
          cell_value_next = '0;
          cursor_row_next = cur_row;
          cursor_col_next = cur_col;
          scrolled_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      cur_row   <= cur_row_next;
      cur_col   <= cur_col_next;
      top       <= top_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    blank_base  <= blank_base_next;
    blank_col   <= blank_col_next;
    rd_in_range <= rd_in_range_next;
    cell_value  <= cell_value_next;
    cursor_row  <= cursor_row_next;
    cursor_col  <= cursor_col_next;
    scrolled    <= scrolled_next;
  end

endmodule

FILE: hdl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// 80x25 text console: writes characters at a cursor, handles newline,
// return, backspace and scrolling, and reads back screen cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive func, char_code, read_row, read_col and raise push;
//   the item transfers on a clock edge with push high and full low.
//   Result channel: while empty is low the oldest result sits on cell_value,
//   cursor_row, cursor_col and scrolled; raise pop to take it.
//   The attribute register lives at APB address 0 and must be written only
//   while the block is idle; the block itself does not enforce this.
// Timing:
//   A two-entry command queue parts the input from the executor. Character,
//   return, newline and backspace items post their result as the executor
//   takes them; a read first passes the S_READ state (one registered memory
//   read port). A scroll blanks the new bottom row column by column in the
//   S_BLANK state before its result is posted.
// Reset:
//   After reset the executor writes blank cells to all 2000 screen entries,
//   one per cycle; full stays high until the clear is done.
// Stalls:
//   With a result waiting and pop low, the executor holds the next command;
//   the queue keeps taking items until it holds two.
// ----------------------------------------------------------------------------
module text_console_char_writer import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               func,
  input  logic [7:0]         char_code,
  input  logic [ROW_W-1:0]   read_row,
  input  logic [COL_W-1:0]   read_col,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        cell_value,
  output logic [ROW_W-1:0]   cursor_row,
  output logic [COL_W-1:0]   cursor_col,
  output logic               scrolled,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0]   text_attribute;
  logic         cmd_valid;
  cmd_t         cmd;
  back_status_t back_status;
  logic         out_valid;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, text_attribute} : 32'd0;
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= BLANK_ATTR;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      text_attribute <= pwdata[7:0];
    end
  end

  tcw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .char_code   (char_code),
    .read_row    (read_row),
    .read_col    (read_col),
    .back_status (back_status),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd)
  );

  tcw_back u_back (
    .clk            (clk),
    .rst            (rst),
    .text_attribute (text_attribute),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .back_status    (back_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .cell_value     (cell_value),
    .cursor_row     (cursor_row),
    .cursor_col     (cursor_col),
    .scrolled       (scrolled)
  );

endmodule

FILE: test/text_console_char_writer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_char_writer_tb
// Self-checking bench for the 80x25 text console character writer. A queue
// of pending items feeds a clocked driver. A clocked monitor compares each
// result transfer against a screen-and-cursor model that is updated as
// items transfer in. Phases switch the attribute register and the idle
// pattern on both sides.
// ----------------------------------------------------------------------------
module text_console_char_writer_tb import tcw_pkg::*;;

  localparam int          CLK_PERIOD     = 12;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          DRAIN_CYCLES   = 200;
  localparam int          PHASE_ITEMS    = 310;
  localparam logic        FUNC_WRITE     = 1'b0;
  localparam logic        FUNC_READ      = 1'b1;
  localparam logic [2:0]  ATTR_ADDR      = 3'd0;

  typedef struct packed {
    logic             func;
    logic [7:0]       ch;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } console_item_t;

  typedef struct packed {
    logic [15:0]      cell_data;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             scrolled;
  } console_result_t;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic               func;
  logic [7:0]         char_code;
  logic [ROW_W-1:0]   read_row;
  logic [COL_W-1:0]   read_col;
  logic               empty;
  logic               pop;
  logic [15:0]        cell_value;
  logic [ROW_W-1:0]   cursor_row;
  logic [COL_W-1:0]   cursor_col;
  logic               scrolled;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  text_console_char_writer dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .char_code  (char_code),
    .read_row   (read_row),
    .read_col   (read_col),
    .empty      (empty),
    .pop        (pop),
    .cell_value (cell_value),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .scrolled   (scrolled),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  console_item_t   pending_items[$];
  console_result_t expected_results[$];

  logic [15:0] screen_model [CELL_COUNT];
  int          cur_row;
  int          cur_col;
  logic [7:0]  attr_model;

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int items_sent;
  int results_checked;
  int scrolls_seen;
  int oob_reads;
  int attr_settings;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Screen and cursor model
  // --------------------------------------------------------------------------
  function automatic logic advance_row();
    cur_row++;
    if (cur_row < SCREEN_ROWS) return 1'b0;
    for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++)
      screen_model[i] = screen_model[i + SCREEN_COLUMNS];
    for (int c = 0; c < SCREEN_COLUMNS; c++)
      screen_model[CELL_COUNT - SCREEN_COLUMNS + c] = BLANK_CELL;
    cur_row = SCREEN_ROWS - 1;
    return 1'b1;
  endfunction

  function automatic console_result_t predict_console(console_item_t it);
    console_result_t r;
    r = '0;
    if (it.func == FUNC_READ) begin
      if (it.row < SCREEN_ROWS && it.col < SCREEN_COLUMNS)
        r.cell_data = screen_model[int'(it.row) * SCREEN_COLUMNS + int'(it.col)];
      else
        oob_reads++;
    end else if (it.ch == CH_NEWLINE) begin
      cur_col = 0;
      r.scrolled = advance_row();
    end else if (it.ch == CH_RETURN) begin
      cur_col = 0;
    end else if (it.ch == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
        screen_model[cur_row * SCREEN_COLUMNS + cur_col] = BLANK_CELL;
      end
    end else begin
      screen_model[cur_row * SCREEN_COLUMNS + cur_col] = {attr_model, it.ch};
      cur_col++;
      if (cur_col >= SCREEN_COLUMNS) begin
        cur_col = 0;
        r.scrolled = advance_row();
      end
    end
    r.row = cur_row[ROW_W-1:0];
    r.col = cur_col[COL_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_write(input logic [7:0] ch);
    console_item_t it;
    it.func = FUNC_WRITE;
    it.ch   = ch;
    it.row  = ROW_W'($urandom_range(31));
    it.col  = COL_W'($urandom_range(127));
    pending_items.push_back(it);
  endtask

  task automatic queue_read(input int row, input int col);
    console_item_t it;
    it.func = FUNC_READ;
    it.ch   = 8'($urandom_range(255));
    it.row  = ROW_W'(row);
    it.col  = COL_W'(col);
    pending_items.push_back(it);
  endtask

  function automatic logic [7:0] ordinary_char();
    logic [7:0] ch;
    ch = 8'($urandom_range(255));
    if (ch == CH_NEWLINE || ch == CH_RETURN || ch == CH_BACKSPACE) ch ^= 8'h40;
    return ch;
  endfunction

  task automatic queue_any_read();
    if ($urandom_range(9) == 0)
      queue_read($urandom_range(31), $urandom_range(127));
    else
      queue_read($urandom_range(SCREEN_ROWS - 1), $urandom_range(SCREEN_COLUMNS - 1));
  endtask

  // Mostly lines of text with a terminator, plus runs of blank lines and noise.
  task automatic queue_random_phase(input int count);
    int start;
    int kind;
    int len;
    start = pending_items.size();
    while (pending_items.size() - start < count) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(70, 95) : $urandom_range(0, 20);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) queue_write(CH_BACKSPACE);
          else queue_write(ordinary_char());
        end
        queue_write(($urandom_range(4) == 0) ? CH_RETURN : CH_NEWLINE);
        repeat ($urandom_range(3)) queue_any_read();
      end else if (kind < 75) begin
        repeat ($urandom_range(5, 30)) queue_write(CH_NEWLINE);
      end else begin
        if ($urandom_range(1)) queue_write(8'($urandom_range(255)));
        else queue_any_read();
      end
    end
  endtask

  task automatic write_attribute(input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    // register takes the value at this edge
    @(posedge clk);
    attr_model = value;
    attr_settings++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || expected_results.size() != 0 || push)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the head of the pending queue, hold it until it transfers
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    console_item_t nxt;
    logic          drive;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(predict_console(pending_items.pop_front()));
        items_sent++;
      end
      if (push && full) begin
        drive = 1'b1;
      end else begin
        drive = pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (drive) begin
          nxt       = pending_items[0];
          func      <= nxt.func;
          char_code <= nxt.ch;
          read_row  <= nxt.row;
          read_col  <= nxt.col;
        end
      end
      push <= drive;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    console_result_t exp_r;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: cell 0x%h row %0d col %0d scrolled %0d",
                   $time, cell_value, cursor_row, cursor_col, scrolled);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("cell_value", exp_r.cell_data, cell_value);
          check_field("cursor_row", exp_r.row, cursor_row);
          check_field("cursor_col", exp_r.col, cursor_col);
          check_field("scrolled", exp_r.scrolled, scrolled);
          results_checked++;
          if (exp_r.scrolled) scrolls_seen++;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    pop       = 1'b0;
    func      = FUNC_WRITE;
    char_code = 8'd0;
    read_row  = '0;
    read_col  = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = ATTR_ADDR;
    pwdata    = 32'd0;
    idle_cycles     = 0;
    error_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    scrolls_seen    = 0;
    oob_reads       = 0;
    attr_settings   = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = BLANK_CELL;
    cur_row    = 0;
    cur_col    = 0;
    attr_model = BLANK_ATTR;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_attribute(8'h3C);
    @(negedge clk);
    // backspace at column 0 changes nothing; reads at corners and out of range
    queue_write(CH_BACKSPACE);
    queue_read(0, 0);
    queue_read(SCREEN_ROWS - 1, SCREEN_COLUMNS - 1);
    queue_read(SCREEN_ROWS, 0);
    queue_read(0, SCREEN_COLUMNS);
    queue_read(31, 127);
    queue_write(8'h00);
    queue_write(8'hFF);
    queue_write(8'h80);
    queue_write(8'h7F);
    queue_write(8'h41);
    queue_write(CH_BACKSPACE);
    queue_read(0, 4);
    queue_read(0, 1);
    queue_write(CH_RETURN);
    queue_write(CH_SPACE);
    queue_write(CH_NEWLINE);
    queue_write(8'h09);
    queue_write(8'h0B);
    queue_write(8'h0C);
    queue_write(8'h0E);
    queue_read(0, 0);
    queue_read(1, 0);
    wait_idle();

    write_attribute(8'h00);
    @(negedge clk);
    queue_random_phase(PHASE_ITEMS);
    wait_idle();

    write_attribute(8'hFF);
    @(negedge clk);
    send_idle_pct = 55;
    queue_random_phase(PHASE_ITEMS);
    wait_idle();

    write_attribute(8'($urandom_range(255)));
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 55;
    queue_random_phase(PHASE_ITEMS);
    wait_idle();

    write_attribute(8'($urandom_range(255)));
    @(negedge clk);
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    queue_random_phase(PHASE_ITEMS);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items over %0d attribute settings; checked %0d results.",
             items_sent, attr_settings, results_checked);
    $display("Saw %0d scrolls and %0d out-of-range reads.", scrolls_seen, oob_reads);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
